>>> rtl/trc_pkg.sv
// ----------------------------------------------------------------------------
// trc_pkg
// Shared types and constants for the thermal relay controller.
// ----------------------------------------------------------------------------
package trc_pkg;

  typedef enum logic [2:0] {
    MODE_FAN_OFF = 3'd0,
    MODE_FAN_ON  = 3'd1,
    MODE_OH      = 3'd2,
    MODE_TRIP    = 3'd3,
    MODE_TEST    = 3'd4,
    MODE_MUTE    = 3'd5
  } mode_e;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_FAN_OFF  = 3'd0,
    CFG_FAN_ON   = 3'd1,
    CFG_OH       = 3'd2,
    CFG_TRIP     = 3'd3,
    CFG_PERIOD   = 3'd4
  } cfg_idx_e;

  // relay bit positions in the pin level vector
  localparam int unsigned PinTrip = 0;
  localparam int unsigned PinOh   = 1;
  localparam int unsigned PinSens = 2;
  localparam int unsigned PinFan  = 3;

  localparam logic [7:0] FanOffRst  = 8'd50;
  localparam logic [7:0] FanOnRst   = 8'd60;
  localparam logic [7:0] OhRst      = 8'd80;
  localparam logic [7:0] TripRst    = 8'd100;
  localparam logic [7:0] PeriodRst  = 8'd0;

  localparam logic [5:0] ReleaseMin = 6'd10;
  localparam logic [5:0] ReleaseSec = 6'd1;

  localparam int unsigned InDataW  = 48;
  localparam int unsigned OutDataW = 16;

  // whole degrees to tenths: x*10 = x*8 + x*2
  function automatic logic [11:0] deg_to_tenths(input logic [7:0] deg);
    logic [11:0] d;
    d = {4'd0, deg};
    return (d << 3) + (d << 1);
  endfunction

endpackage

>>> rtl/thermal_relay_controller.sv
// ----------------------------------------------------------------------------
// thermal_relay_controller
// Timed-fan rule and mode/threshold ladder driving four relay pins per tick.
// ----------------------------------------------------------------------------
// An input beat reaches the result beat through the input reg and then the result reg.
// Throughput: one beat per cycle; the state update sits between the two regs.
// Backpressure on the result side stalls both stages; the input side keeps
// taking a beat while the input reg is empty.
// Reset: mode fan off, all relays inactive (1), timed fan clear, registers at
// their defaults; usable as soon as reset is released.
module thermal_relay_controller
  import trc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_idx_i,
  input  logic [7:0]          cfg_wdata_i,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // max_temp[15:0], channel_errors[18:16], alarm_test[19], force_mute[20],
  // force_fan_on[21], clock_hour[29:22], clock_minute[35:30],
  // clock_second[41:36], zero pad[47:42]
  input  logic [InDataW-1:0]  s_axis_tdata_i,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // trip_relay[0], overheat_relay[1], sensor_fault_relay[2], fan_relay[3],
  // mode[6:4], clear_clock[7], record_trip[8], zero pad[15:9]
  output logic [OutDataW-1:0] m_axis_tdata_o
);

  logic [7:0] fan_off_q, fan_on_q, oh_q, trip_q, period_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fan_off_q <= FanOffRst;
      fan_on_q  <= FanOnRst;
      oh_q      <= OhRst;
      trip_q    <= TripRst;
      period_q  <= PeriodRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_FAN_OFF: fan_off_q <= cfg_wdata_i;
        CFG_FAN_ON:  fan_on_q  <= cfg_wdata_i;
        CFG_OH:      oh_q      <= cfg_wdata_i;
        CFG_TRIP:    trip_q    <= cfg_wdata_i;
        CFG_PERIOD:  period_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // ---- input stage ----
  logic               in_vld_q;
  logic [InDataW-1:0] in_data_q;
  logic               out_vld_q;
  logic [8:0]         out_data_q;
  logic               adv;

  assign adv             = in_vld_q && (!out_vld_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_vld_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_vld_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_data_q <= s_axis_tdata_i;
    end
  end

  // ---- field unpack ----
  logic signed [15:0] temp;
  logic [2:0]         errs;
  logic               test, mute, forced;
  logic [7:0]         hour;
  logic [5:0]         minute, second;

  assign temp   = $signed(in_data_q[15:0]);
  assign errs   = in_data_q[18:16];
  assign test   = in_data_q[19];
  assign mute   = in_data_q[20];
  assign forced = in_data_q[21];
  assign hour   = in_data_q[29:22];
  assign minute = in_data_q[35:30];
  assign second = in_data_q[41:36];

  // ---- timed-fan period split: hours = p/5, minutes = (p%5)*12 ----
  logic [17:0] per_mul;
  logic [7:0]  per_hr;
  logic [7:0]  per_five;
  logic [2:0]  per_rem;
  logic [5:0]  per_min;

  // p*205 >> 10 equals p/5 for every 8-bit p
  assign per_mul  = {10'd0, period_q} * 18'd205;
  assign per_hr   = {2'b00, per_mul[15:10]};
  assign per_five = (per_hr << 2) + per_hr;
  assign per_rem  = 3'(period_q - per_five);
  assign per_min  = ({3'd0, per_rem} << 3) + ({3'd0, per_rem} << 2);

  // ---- thresholds in tenths ----
  logic signed [16:0] temp_x, thr_trip, thr_oh, thr_on, thr_off;

  assign temp_x   = 17'(temp);
  assign thr_trip = $signed({5'd0, deg_to_tenths(trip_q)});
  assign thr_oh   = $signed({5'd0, deg_to_tenths(oh_q)});
  assign thr_on   = $signed({5'd0, deg_to_tenths(fan_on_q)});
  assign thr_off  = $signed({5'd0, deg_to_tenths(fan_off_q)});

  // ---- state ----
  mode_e      mode_q, mode_d;
  logic [3:0] relay_q, relay_d;
  logic       tfa_q, tfa_d;
  logic       clr, rec;

  always_comb begin
    mode_d  = mode_q;
    relay_d = relay_q;
    tfa_d   = tfa_q;
    clr     = 1'b0;
    rec     = 1'b0;

    if (period_q != 8'd0 && hour >= per_hr && minute >= per_min) begin
      clr = 1'b1;
      if (relay_d[PinFan]) begin
        relay_d[PinFan] = 1'b0;
        tfa_d           = 1'b1;
      end
    end
    if (hour == 8'd0 && minute == ReleaseMin && second <= ReleaseSec && tfa_d) begin
      tfa_d = 1'b0;
      if (!forced) relay_d[PinFan] = 1'b1;
    end

    priority if (test) begin
      mode_d  = MODE_TEST;
      relay_d = 4'b0000;
    end else if (mute) begin
      mode_d           = MODE_MUTE;
      relay_d[PinTrip] = 1'b1;
      relay_d[PinOh]   = 1'b1;
      relay_d[PinSens] = 1'b1;
    end else begin
      relay_d[PinSens] = (errs == 3'd0);
      priority if (temp_x > thr_trip) begin
        if (mode_q != MODE_TRIP) begin
          mode_d           = MODE_TRIP;
          relay_d[PinTrip] = 1'b0;
          relay_d[PinOh]   = 1'b0;
          relay_d[PinFan]  = 1'b0;
          rec              = 1'b1;
        end
      end else if (temp_x > thr_oh) begin
        if (mode_q != MODE_OH) begin
          mode_d           = MODE_OH;
          relay_d[PinTrip] = 1'b1;
          relay_d[PinOh]   = 1'b0;
          relay_d[PinFan]  = 1'b0;
        end
      end else if (temp_x > thr_on) begin
        if (mode_q != MODE_FAN_ON) begin
          mode_d           = MODE_FAN_ON;
          relay_d[PinTrip] = 1'b1;
          relay_d[PinOh]   = 1'b1;
          relay_d[PinFan]  = 1'b0;
        end
      end else if (temp_x < thr_off) begin
        if (mode_q != MODE_FAN_OFF) begin
          mode_d           = MODE_FAN_OFF;
          relay_d[PinTrip] = 1'b1;
          relay_d[PinOh]   = 1'b1;
          relay_d[PinFan]  = 1'b1;
        end
      end else begin
        // hysteresis band: hold mode and pins
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_FAN_OFF;
      relay_q <= 4'hF;
      tfa_q   <= 1'b0;
    end else if (adv) begin
      mode_q  <= mode_d;
      relay_q <= relay_d;
      tfa_q   <= tfa_d;
    end
  end

  // ---- result stage ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (!out_vld_q || m_axis_tready_i) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_data_q <= {rec, clr, mode_d, relay_d};
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {7'd0, out_data_q};

  // ---- assertions ----
  // a trip record beat always reports trip mode with trip, overheat, fan active
  a_rec_trip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_data_q[8] |->
      out_data_q[6:4] == MODE_TRIP && out_data_q[PinTrip] == 1'b0
      && out_data_q[PinOh] == 1'b0 && out_data_q[PinFan] == 1'b0)
    else $error("trip record without trip pins");

  // a stalled result beat holds its data
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result beat changed while stalled");

  // state only moves when a beat passes into the result stage
  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(mode_q) && $stable(relay_q) && $stable(tfa_q))
    else $error("state changed without a beat");

  // an empty input register always takes a beat
  a_in_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_vld_q |-> s_axis_tready_o)
    else $error("input stalled while empty");

endmodule
